// File: rtl/mm4_pkg.sv
// ----------------------------------------------------------------------------
// mm4_pkg
// Shared types and constants for the 4x4 fixed-point matrix multiplier.
// ----------------------------------------------------------------------------
package mm4_pkg;

	localparam int DATA_WIDTH_DEF = 32;
	localparam int FRAC_BITS_DEF  = 16;

	localparam int DIM   = 4;
	localparam int IDX_W = 2;

	// column index that carries the final column and starts a product
	localparam logic [IDX_W-1:0] LAST_COL = 2'd3;
	// last inner-product term and last partial product of one term
	localparam logic [IDX_W-1:0] LAST_K    = 2'd3;
	localparam logic [1:0]       LAST_PART = 2'd3;
	localparam logic [1:0]       FIRST_PART = 2'd0;
	localparam logic [IDX_W-1:0] FIRST_K    = 2'd0;

	// shift selector for partial products: 0, one half-width, two half-widths
	localparam logic [1:0] SH_NONE = 2'd0;
	localparam logic [1:0] SH_HALF = 2'd1;
	localparam logic [1:0] SH_FULL = 2'd2;

	// control side of the token that walks down the cell chain
	typedef struct packed {
		logic             valid;
		logic [IDX_W-1:0] col;   // product column being formed
		logic [IDX_W-1:0] k;     // inner-product term
		logic [1:0]       part;  // bit 0: half of A, bit 1: half of B
	} ctl_t;

	// finished-column flag out of a cell
	typedef struct packed {
		logic             done;
		logic [IDX_W-1:0] col;
	} res_ctl_t;

endpackage

// File: rtl/matrix_multiply_4x4.sv
// ----------------------------------------------------------------------------
// matrix_multiply_4x4
// Column-major 4x4 signed fixed-point product R = A*B, one row cell per row.
// ----------------------------------------------------------------------------
// Columns 0..2 are only stored; column 3 is stored too and starts a product,
// whose columns then come out in order 0..3, each from 4 terms x 4 partials.
// s_axis_tready is low while a product runs, until its last column is
// captured; output stalls freeze the chain and the sequencer.
// Reset: arst_n clears all control; stored matrices are undefined until written.
// ----------------------------------------------------------------------------
//
// Structure
//   mm4_seq   keeps B and, unless frozen, issues a token per cycle: {col, k, part} + B[k][col].
//   mm4_cell  x4, one per row r, holds A row r. A token visits cell 0 first and
//             is passed down through a register in each cell, so cell r sees
//             it after cell r-1. Each cell multiplies a half of A[r][k] by a
//             half of B[k][col] (four partials per term), accumulates exactly,
//             then shifts by FRAC_BITS and saturates.
//   When the last cell flags a finished column, all four cells hold that column
//   (cell 0 overwrites its result only when it finishes its next column), and
//   it is copied into the output register. If that register is still full and
//   not being taken, the whole chain and the sequencer freeze for the cycle.
//
module matrix_multiply_4x4 #(
	parameter int DATA_WIDTH = mm4_pkg::DATA_WIDTH_DEF,
	parameter int FRAC_BITS  = mm4_pkg::FRAC_BITS_DEF
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	// input stream
	input  logic                                  s_axis_tvalid,
	output logic                                  s_axis_tready,
	// a_row0, a_row1, a_row2, a_row3, b_row0, b_row1, b_row2, b_row3
	input  logic [((8*DATA_WIDTH+7)/8)*8-1:0]     s_axis_tdata,
	// col_index
	input  logic [mm4_pkg::IDX_W-1:0]             s_axis_tuser,
	// result stream
	output logic                                  m_axis_tvalid,
	input  logic                                  m_axis_tready,
	// r_row0, r_row1, r_row2, r_row3
	output logic [((4*DATA_WIDTH+7)/8)*8-1:0]     m_axis_tdata,
	// out_col
	output logic [mm4_pkg::IDX_W-1:0]             m_axis_tuser,
	// is_last
	output logic                                  m_axis_tlast
);
	import mm4_pkg::*;

	localparam int OUT_TW = ((4 * DATA_WIDTH + 7) / 8) * 8;

	logic                  busy_q;
	logic                  in_xfer;
	logic                  start;
	logic                  adv;

	// token chain between sequencer and cells
	ctl_t                  chain_ctl [DIM];
	logic [DATA_WIDTH-1:0] chain_b   [DIM];
	res_ctl_t              last_res_ctl;
	logic [DATA_WIDTH-1:0] cell_res  [DIM];

	// output holding register
	logic                    out_valid_q;
	logic [IDX_W-1:0]        out_col_q;
	logic                    out_last_q;
	logic [4*DATA_WIDTH-1:0] out_data_q;
	logic                    capture;

	assign s_axis_tready = !busy_q;
	assign in_xfer       = s_axis_tvalid && s_axis_tready;
	assign start         = in_xfer && s_axis_tuser == LAST_COL;

	// freeze everything while a finished column cannot be handed over
	assign adv     = !(last_res_ctl.done && out_valid_q && !m_axis_tready);
	assign capture = last_res_ctl.done && adv;

	mm4_seq #(
		.DATA_WIDTH(DATA_WIDTH)
	) u_seq (
		.clk     (clk),
		.arst_n  (arst_n),
		.adv     (adv),
		.wr_en   (in_xfer),
		.wr_col  (s_axis_tuser),
		.wr_data (s_axis_tdata[8*DATA_WIDTH-1:4*DATA_WIDTH]),
		.start   (start),
		.ctl_o   (chain_ctl[0]),
		.b_o     (chain_b[0])
	);

	for (genvar i = 0; i < DIM; i++) begin : g_cell
		if (i < DIM - 1) begin : g_mid
			mm4_cell #(
				.DATA_WIDTH(DATA_WIDTH),
				.FRAC_BITS (FRAC_BITS)
			) u_cell (
				.clk       (clk),
				.arst_n    (arst_n),
				.adv       (adv),
				.wr_en     (in_xfer),
				.wr_col    (s_axis_tuser),
				.wr_data   (s_axis_tdata[i*DATA_WIDTH +: DATA_WIDTH]),
				.ctl_i     (chain_ctl[i]),
				.b_i       (chain_b[i]),
				.ctl_o     (chain_ctl[i+1]),
				.b_o       (chain_b[i+1]),
				.res_ctl_o (),
				.res_o     (cell_res[i])
			);
		end else begin : g_end
			// last cell: its finished flag drives the output capture
			mm4_cell #(
				.DATA_WIDTH(DATA_WIDTH),
				.FRAC_BITS (FRAC_BITS)
			) u_cell (
				.clk       (clk),
				.arst_n    (arst_n),
				.adv       (adv),
				.wr_en     (in_xfer),
				.wr_col    (s_axis_tuser),
				.wr_data   (s_axis_tdata[i*DATA_WIDTH +: DATA_WIDTH]),
				.ctl_i     (chain_ctl[i]),
				.b_i       (chain_b[i]),
				.ctl_o     (),
				.b_o       (),
				.res_ctl_o (last_res_ctl),
				.res_o     (cell_res[i])
			);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (start) begin
				busy_q <= 1'b1;
			end else if (capture && last_res_ctl.col == LAST_COL) begin
				busy_q <= 1'b0;
			end
			if (capture) begin
				out_valid_q <= 1'b1;
			end else if (m_axis_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (capture) begin
			out_col_q  <= last_res_ctl.col;
			out_last_q <= last_res_ctl.col == LAST_COL;
			for (int r = 0; r < DIM; r++) begin
				out_data_q[r*DATA_WIDTH +: DATA_WIDTH] <= cell_res[r];
			end
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = OUT_TW'(out_data_q);
	assign m_axis_tuser  = out_col_q;
	assign m_axis_tlast  = out_last_q;

endmodule

// File: rtl/mm4_cell.sv
// ----------------------------------------------------------------------------
// mm4_cell
// One row cell: holds a row of A, runs a split multiply-accumulate on the
// tokens passing by, finishes one product entry per column.
// ----------------------------------------------------------------------------
module mm4_cell #(
	parameter int DATA_WIDTH = mm4_pkg::DATA_WIDTH_DEF,
	parameter int FRAC_BITS  = mm4_pkg::FRAC_BITS_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         adv,
	input  logic                         wr_en,
	input  logic [mm4_pkg::IDX_W-1:0]    wr_col,
	input  logic [DATA_WIDTH-1:0]        wr_data,
	input  mm4_pkg::ctl_t                ctl_i,
	input  logic [DATA_WIDTH-1:0]        b_i,
	output mm4_pkg::ctl_t                ctl_o,
	output logic [DATA_WIDTH-1:0]        b_o,
	output mm4_pkg::res_ctl_t            res_ctl_o,
	output logic [DATA_WIDTH-1:0]        res_o
);
	import mm4_pkg::*;

	localparam int H  = (DATA_WIDTH + 1) / 2;
	localparam int PW = 2 * H + 2;
	localparam int AW = 2 * DATA_WIDTH + 2;

	logic [DATA_WIDTH-1:0] a_q [DIM];

	ctl_t                  tok_ctl_q;
	logic [DATA_WIDTH-1:0] tok_b_q;

	ctl_t                  ctl_s1;
	logic signed [PW-1:0]  prod_s1;
	logic [1:0]            sh_s1;

	ctl_t                  ctl_s2;
	logic signed [AW-1:0]  acc_s2;

	res_ctl_t              res_ctl_q;
	logic [DATA_WIDTH-1:0] res_q;

	logic [DATA_WIDTH-1:0] a_sel;
	logic signed [H:0]     op_a;
	logic signed [H:0]     op_b;
	logic signed [AW-1:0]  ext;
	logic signed [AW-1:0]  addend;
	logic signed [AW-1:0]  shifted;
	logic                  fits;
	logic [DATA_WIDTH-1:0] sat;

	// operand halves: low half unsigned, high half signed
	always_comb begin
		a_sel = a_q[ctl_i.k];
		if (ctl_i.part[0]) begin
			op_a = (H+1)'($signed(a_sel[DATA_WIDTH-1:H]));
		end else begin
			op_a = $signed({1'b0, a_sel[H-1:0]});
		end
		if (ctl_i.part[1]) begin
			op_b = (H+1)'($signed(b_i[DATA_WIDTH-1:H]));
		end else begin
			op_b = $signed({1'b0, b_i[H-1:0]});
		end
	end

	always_comb begin
		ext = AW'(prod_s1);
		unique case (sh_s1)
			SH_NONE: addend = ext;
			SH_HALF: addend = ext <<< H;
			SH_FULL: addend = ext <<< (2 * H);
			default: addend = ext;
		endcase
	end

	// scale down and clamp to the data range
	always_comb begin
		shifted = acc_s2 >>> FRAC_BITS;
		fits    = (&shifted[AW-1:DATA_WIDTH-1]) || !(|shifted[AW-1:DATA_WIDTH-1]);
		if (fits) begin
			sat = shifted[DATA_WIDTH-1:0];
		end else if (acc_s2[AW-1]) begin
			sat = {1'b1, {(DATA_WIDTH-1){1'b0}}};
		end else begin
			sat = {1'b0, {(DATA_WIDTH-1){1'b1}}};
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			a_q[wr_col] <= wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tok_ctl_q <= '0;
			ctl_s1    <= '0;
			ctl_s2    <= '0;
			res_ctl_q <= '0;
		end else if (adv) begin
			tok_ctl_q <= ctl_i;
			ctl_s1    <= ctl_i;
			ctl_s2    <= ctl_s1;
			res_ctl_q.done <= ctl_s2.valid && ctl_s2.k == LAST_K && ctl_s2.part == LAST_PART;
			res_ctl_q.col  <= ctl_s2.col;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			tok_b_q <= b_i;
			prod_s1 <= op_a * op_b;
			sh_s1   <= {1'b0, ctl_i.part[0]} + {1'b0, ctl_i.part[1]};
			if (ctl_s1.valid) begin
				if (ctl_s1.k == FIRST_K && ctl_s1.part == FIRST_PART) begin
					acc_s2 <= addend;
				end else begin
					acc_s2 <= acc_s2 + addend;
				end
			end
			if (ctl_s2.valid && ctl_s2.k == LAST_K && ctl_s2.part == LAST_PART) begin
				res_q <= sat;
			end
		end
	end

	assign ctl_o     = tok_ctl_q;
	assign b_o       = tok_b_q;
	assign res_ctl_o = res_ctl_q;
	assign res_o     = res_q;

endmodule

// File: rtl/mm4_seq.sv
// ----------------------------------------------------------------------------
// mm4_seq
// Holds B and, unless frozen, issues one token per cycle into the cell chain:
// 64 tokens per product, ordered column, term, partial product.
// ----------------------------------------------------------------------------
module mm4_seq #(
	parameter int DATA_WIDTH = mm4_pkg::DATA_WIDTH_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         adv,
	input  logic                         wr_en,
	input  logic [mm4_pkg::IDX_W-1:0]    wr_col,
	input  logic [4*DATA_WIDTH-1:0]      wr_data,
	input  logic                         start,
	output mm4_pkg::ctl_t                ctl_o,
	output logic [DATA_WIDTH-1:0]        b_o
);
	import mm4_pkg::*;

	localparam int CNT_W = 3 * IDX_W;

	logic [DATA_WIDTH-1:0] b_mem [DIM*DIM];
	logic                  run_q;
	logic [CNT_W-1:0]      cnt_q;
	ctl_t                  ctl_q;
	logic [DATA_WIDTH-1:0] b_q;

	// B[row][col] kept at {col, row}
	always_ff @(posedge clk) begin
		if (wr_en) begin
			for (int r = 0; r < DIM; r++) begin
				b_mem[{wr_col, IDX_W'(r)}] <= wr_data[r*DATA_WIDTH +: DATA_WIDTH];
			end
		end
		if (adv && run_q) begin
			b_q <= b_mem[cnt_q[CNT_W-1:2]];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q <= 1'b0;
			cnt_q <= '0;
			ctl_q <= '0;
		end else if (start) begin
			run_q <= 1'b1;
			cnt_q <= '0;
			ctl_q <= '0;
		end else if (adv) begin
			ctl_q.valid <= run_q;
			ctl_q.col   <= cnt_q[CNT_W-1:CNT_W-IDX_W];
			ctl_q.k     <= cnt_q[2*IDX_W-1:IDX_W];
			ctl_q.part  <= cnt_q[1:0];
			if (run_q) begin
				cnt_q <= cnt_q + CNT_W'(1);
				if (&cnt_q) begin
					run_q <= 1'b0;
				end
			end
		end
	end

	assign ctl_o = ctl_q;
	assign b_o   = b_q;

endmodule

// File: dv/tb_matrix_multiply_4x4.sv
// ----------------------------------------------------------------------------
// tb_matrix_multiply_4x4
// Self-checking bench for the 4x4 Q16.16 matrix multiplier. Column
// transactions are driven on the input stream and a local model keeps both
// matrices. It queues the four expected product columns whenever column 3
// is accepted. Each result transaction is checked against the oldest
// queued column. Directed tests cover identity, saturation, floor rounding
// and column rewrites. Random traffic then runs under four idle/stall mixes.
// ----------------------------------------------------------------------------
module tb_matrix_multiply_4x4;
	timeunit 1ns;
	timeprecision 1ps;

	import mm4_pkg::*;

	localparam int  DW        = DATA_WIDTH_DEF;
	localparam int  FRAC      = FRAC_BITS_DEF;
	localparam int  CYCLE_CAP = 400000;
	localparam int  DRAIN     = 60;      // well over the latency of one product column

	localparam logic [DW-1:0] Q_MAX  = 32'h7FFF_FFFF;
	localparam logic [DW-1:0] Q_MIN  = 32'h8000_0000;
	localparam logic [DW-1:0] Q_ONE  = 32'h0001_0000;   // 1.0
	localparam logic [DW-1:0] Q_NONE = 32'hFFFF_0000;   // -1.0
	localparam logic [DW-1:0] Q_LSB  = 32'h0000_0001;   // 2^-16
	localparam logic [DW-1:0] Q_NLSB = 32'hFFFF_FFFF;   // -2^-16

	// value mixes for random columns
	typedef enum int {MIX_FULL, MIX_SMALL, MIX_CORNER, MIX_ANY} mix_t;

	typedef logic [DIM-1:0][DW-1:0] mat_col_t;   // [row], row 0 in low bits

	// one expected product column
	typedef struct packed {
		logic [IDX_W-1:0] col;
		mat_col_t         rows;
		logic             last;
	} prod_col_t;

	logic clk    = 1'b0;
	logic arst_n = 1'b0;

	logic                 s_axis_tvalid = 1'b0;
	logic                 s_axis_tready;
	logic [8*DW-1:0]      s_axis_tdata  = '0;
	logic [IDX_W-1:0]     s_axis_tuser  = '0;
	logic                 m_axis_tvalid;
	logic                 m_axis_tready = 1'b0;
	logic [4*DW-1:0]      m_axis_tdata;
	logic [IDX_W-1:0]     m_axis_tuser;
	logic                 m_axis_tlast;

	// model of the stored matrices, [col][row]
	mat_col_t   left_cols  [DIM];
	mat_col_t   right_cols [DIM];
	logic [DIM-1:0] cols_written = '0;

	prod_col_t  pending_cols[$];
	prod_col_t  got_col;

	int src_idle_pct   = 0;
	int sink_stall_pct = 0;
	int cycle_count    = 0;
	int error_count    = 0;
	int col_xfers      = 0;
	int products       = 0;
	int cols_checked   = 0;

	matrix_multiply_4x4 u_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser),
		.m_axis_tlast  (m_axis_tlast)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// --------------------------------------------------------------------
	// Prediction
	// --------------------------------------------------------------------

	// R[row][col] = sum_k A[row][k] * B[k][col], floor shift, saturate
	function automatic logic [DW-1:0] dot_q16(int row, int col);
		logic signed [2*DW-1:0] term;
		logic signed [2*DW+3:0] acc;
		logic signed [2*DW+3:0] shifted;
		acc = '0;
		for (int k = 0; k < DIM; k++) begin
			term = $signed(left_cols[k][row]) * $signed(right_cols[col][k]);
			acc  = acc + term;
		end
		shifted = acc >>> FRAC;
		if (shifted > $signed({{(DW+4){1'b0}}, Q_MAX}))
			return Q_MAX;
		if (shifted < $signed({{(DW+4){1'b1}}, Q_MIN}))
			return Q_MIN;
		return shifted[DW-1:0];
	endfunction

	// store the accepted column; column 3 queues the whole product
	task automatic store_and_predict(logic [IDX_W-1:0] col, mat_col_t a_col, mat_col_t b_col);
		prod_col_t pc;
		left_cols[col]    = a_col;
		right_cols[col]   = b_col;
		cols_written[col] = 1'b1;
		col_xfers++;
		if (col == LAST_COL) begin
			products++;
			for (int c = 0; c < DIM; c++) begin
				pc.col  = IDX_W'(c);
				pc.last = (c == DIM - 1);
				for (int r = 0; r < DIM; r++)
					pc.rows[r] = dot_q16(r, c);
				pending_cols.push_back(pc);
			end
		end
	endtask

	// --------------------------------------------------------------------
	// Driving
	// --------------------------------------------------------------------

	// Called right after a falling edge. Leaves tvalid high after the
	// transaction so back-to-back columns keep it asserted; the next call
	// either replaces the data in the same step or drops tvalid for a gap.
	task automatic send_column(logic [IDX_W-1:0] col, mat_col_t a_col, mat_col_t b_col);
		while ($urandom_range(99) < src_idle_pct) begin
			s_axis_tvalid = 1'b0;
			@(negedge clk);
		end
		s_axis_tvalid = 1'b1;
		s_axis_tdata  = {b_col, a_col};
		s_axis_tuser  = col;
		do @(posedge clk); while (!s_axis_tready);
		store_and_predict(col, a_col, b_col);
		@(negedge clk);
	endtask

	task automatic stop_sending();
		s_axis_tvalid = 1'b0;
	endtask

	// receiver stall, redrawn every falling edge
	always @(negedge clk)
		m_axis_tready = ($urandom_range(99) >= sink_stall_pct);

	// --------------------------------------------------------------------
	// Checking
	// --------------------------------------------------------------------
	always @(posedge clk) begin
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			if (pending_cols.size() == 0) begin
				$display("%0t: unexpected product column: col %0d data %h last %b",
					$time, m_axis_tuser, m_axis_tdata, m_axis_tlast);
				error_count++;
			end else begin
				got_col = pending_cols.pop_front();
				cols_checked++;
				if (m_axis_tuser !== got_col.col) begin
					$display("%0t: out_col expected %0d actual %0d",
						$time, got_col.col, m_axis_tuser);
					error_count++;
				end
				for (int r = 0; r < DIM; r++)
					if (m_axis_tdata[DW*r +: DW] !== got_col.rows[r]) begin
						$display("%0t: col %0d row %0d expected %h actual %h",
							$time, got_col.col, r, got_col.rows[r],
							m_axis_tdata[DW*r +: DW]);
						error_count++;
					end
				if (m_axis_tlast !== got_col.last) begin
					$display("%0t: is_last col %0d expected %b actual %b",
						$time, got_col.col, got_col.last, m_axis_tlast);
					error_count++;
				end
			end
		end
	end

	// hang guard
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_CAP) begin
			$display("%0t: timeout, %0d product columns still pending",
				$time, pending_cols.size());
			$display("FAILURE");
			$finish;
		end
	end

	// --------------------------------------------------------------------
	// Stimulus helpers
	// --------------------------------------------------------------------
	function automatic logic [DW-1:0] pick_entry(mix_t mix);
		mix_t m;
		m = (mix == MIX_ANY) ? mix_t'($urandom_range(2)) : mix;
		case (m)
			MIX_SMALL: begin
				// about -8.0 .. 8.0
				return DW'($signed($urandom_range(32'h0010_0000)) - 32'sh0008_0000);
			end
			MIX_CORNER: begin
				case ($urandom_range(6))
					0: return Q_MAX;
					1: return Q_MIN;
					2: return '0;
					3: return Q_ONE;
					4: return Q_NONE;
					5: return Q_LSB;
					default: return Q_NLSB;
				endcase
			end
			default: return $urandom();
		endcase
	endfunction

	function automatic mat_col_t pick_col(mix_t mix);
		mat_col_t v;
		for (int r = 0; r < DIM; r++)
			v[r] = pick_entry(mix);
		return v;
	endfunction

	function automatic mat_col_t fill_col(logic [DW-1:0] x);
		mat_col_t v;
		for (int r = 0; r < DIM; r++)
			v[r] = x;
		return v;
	endfunction

	// identity column scaled by one Q16.16 value
	function automatic mat_col_t diag_col(int col, logic [DW-1:0] x);
		mat_col_t v;
		v      = '0;
		v[col] = x;
		return v;
	endfunction

	// --------------------------------------------------------------------
	// Tests
	// --------------------------------------------------------------------
	task automatic test_reset();
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);
	endtask

	// A = I, so R = B exactly, with B holding every extreme value
	task automatic test_identity();
		mat_col_t b_col;
		for (int c = 0; c < DIM; c++) begin
			b_col[0] = Q_MAX;
			b_col[1] = Q_MIN;
			b_col[2] = (c < 2) ? Q_LSB : Q_NLSB;
			b_col[3] = $urandom();
			send_column(IDX_W'(c), diag_col(c, Q_ONE), b_col);
		end
	endtask

	// both directions of saturation, plus a zero column
	task automatic test_saturation();
		mat_col_t mixed;
		mixed = {Q_MIN, Q_MAX, Q_NONE, Q_ONE};
		// A all most-negative
		send_column(2'd0, fill_col(Q_MIN), fill_col(Q_MIN));   // huge positive
		send_column(2'd1, fill_col(Q_MIN), fill_col(Q_MAX));   // huge negative
		send_column(2'd2, fill_col(Q_MIN), fill_col('0));
		send_column(LAST_COL, fill_col(Q_MIN), mixed);
		// A and B all most-positive
		for (int c = 0; c < DIM; c++)
			send_column(IDX_W'(c), fill_col(Q_MAX), fill_col(Q_MAX));
	endtask

	// tiny products: the shift floors toward minus infinity
	task automatic test_floor_rounding();
		send_column(2'd0, fill_col(Q_LSB), fill_col(Q_NLSB));  // -4 lsb^2 -> -1 lsb
		send_column(2'd1, fill_col(Q_LSB), fill_col(Q_LSB));   // +4 lsb^2 -> 0
		send_column(2'd2, fill_col(Q_LSB),
			{32'hFFFF_8000, 32'h0000_8000, 32'hFFFF_C000, 32'h0001_0001});
		send_column(LAST_COL, fill_col(Q_LSB),
			{32'hFFFE_8000, 32'h0001_8000, Q_NONE, Q_ONE});
	endtask

	// rewrite a single column, then send column 3 on its own three times
	task automatic test_column_rewrite();
		send_column(2'd1, pick_col(MIX_SMALL), pick_col(MIX_SMALL));
		send_column(LAST_COL, pick_col(MIX_SMALL), pick_col(MIX_SMALL));
		send_column(LAST_COL, pick_col(MIX_FULL), pick_col(MIX_CORNER));
		send_column(LAST_COL, pick_col(MIX_SMALL), pick_col(MIX_FULL));
	endtask

	// mostly full matrix pairs in varied column order, some stray columns
	task automatic test_random_traffic(int n_items, int idle_pct, int stall_pct);
		int          sent;
		int          first;
		int          step;
		mix_t        mix;
		logic [IDX_W-1:0] col;
		src_idle_pct   = idle_pct;
		sink_stall_pct = stall_pct;
		sent = 0;
		while (sent < n_items) begin
			mix = mix_t'($urandom_range(3));
			if ($urandom_range(99) < 80) begin
				first = $urandom_range(2);
				step  = $urandom_range(1) ? 1 : 2;
				for (int i = 0; i < 3; i++)
					send_column(IDX_W'((first + i * step) % 3), pick_col(mix), pick_col(mix));
				send_column(LAST_COL, pick_col(mix), pick_col(mix));
				sent += 4;
			end else begin
				col = IDX_W'($urandom_range(3));
				if (col == LAST_COL && cols_written[2:0] != 3'b111)
					col = 2'd0;
				send_column(col, pick_col(mix), pick_col(mix));
				sent++;
			end
		end
		stop_sending();
		while (pending_cols.size() != 0)
			@(posedge clk);
		@(negedge clk);
	endtask

	initial begin
		test_reset();
		test_identity();
		test_saturation();
		test_floor_rounding();
		test_column_rewrite();
		test_random_traffic(100, 0, 0);
		test_random_traffic(100, 73, 0);
		test_random_traffic(100, 0, 73);
		test_random_traffic(100, 35, 35);
		sink_stall_pct = 0;
		repeat (DRAIN) @(posedge clk);

		$display("Ran %0d column transactions forming %0d matrix products;",
			col_xfers, products);
		$display("checked %0d product columns under four idle/stall mixes, %0d errors.",
			cols_checked, error_count);
		if (error_count == 0 && pending_cols.size() == 0) begin
			$display("SUCCESS");
		end else begin
			$display("FAILURE");
		end
		$finish;
	end

endmodule
